// File: sv/idv_pkg.sv
package idv_pkg;

	// Number of digits in a well-formed ID number.
	localparam int unsigned ID_DIGITS = 12;

	// Result status codes.
	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_BAD_CHAR  = 3'd1;
	localparam logic [2:0] STATUS_BAD_LEN   = 3'd2;
	localparam logic [2:0] STATUS_BAD_LEAD  = 3'd3;
	localparam logic [2:0] STATUS_BAD_CHECK = 3'd4;

	// Character codes that need special handling.
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0d;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2d;

	// One input transaction: a character of the string.
	typedef struct packed {
		logic       has_char;
		logic [7:0] char_code;
		logic       is_last;
	} item_t;

	// One output transaction: the verdict for a whole string.
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] bad_char;
		logic [7:0] digit_count;
	} result_t;

	// Class of one character, from the decoder to the accumulator.
	typedef struct packed {
		logic       is_digit;
		logic       is_bad;
		logic [3:0] digit;
	} char_class_t;

	// Multiplication table of the dihedral group D5.
	localparam logic [3:0] GRP_MUL [10][10] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
		'{4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5},
		'{4'd2, 4'd3, 4'd4, 4'd0, 4'd1, 4'd7, 4'd8, 4'd9, 4'd5, 4'd6},
		'{4'd3, 4'd4, 4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd5, 4'd6, 4'd7},
		'{4'd4, 4'd0, 4'd1, 4'd2, 4'd3, 4'd9, 4'd5, 4'd6, 4'd7, 4'd8},
		'{4'd5, 4'd9, 4'd8, 4'd7, 4'd6, 4'd0, 4'd4, 4'd3, 4'd2, 4'd1},
		'{4'd6, 4'd5, 4'd9, 4'd8, 4'd7, 4'd1, 4'd0, 4'd4, 4'd3, 4'd2},
		'{4'd7, 4'd6, 4'd5, 4'd9, 4'd8, 4'd2, 4'd1, 4'd0, 4'd4, 4'd3},
		'{4'd8, 4'd7, 4'd6, 4'd5, 4'd9, 4'd3, 4'd2, 4'd1, 4'd0, 4'd4},
		'{4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0}
	};

	// Position permutations; row r is the base permutation applied r times.
	localparam logic [3:0] GRP_PERM [8][10] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9},
		'{4'd1, 4'd5, 4'd7, 4'd6, 4'd2, 4'd8, 4'd3, 4'd0, 4'd9, 4'd4},
		'{4'd5, 4'd8, 4'd0, 4'd3, 4'd7, 4'd9, 4'd6, 4'd1, 4'd4, 4'd2},
		'{4'd8, 4'd9, 4'd1, 4'd6, 4'd0, 4'd4, 4'd3, 4'd5, 4'd2, 4'd7},
		'{4'd9, 4'd4, 4'd5, 4'd3, 4'd1, 4'd2, 4'd6, 4'd8, 4'd7, 4'd0},
		'{4'd4, 4'd2, 4'd8, 4'd6, 4'd5, 4'd7, 4'd3, 4'd9, 4'd0, 4'd1},
		'{4'd2, 4'd7, 4'd9, 4'd3, 4'd8, 4'd0, 4'd6, 4'd4, 4'd1, 4'd5},
		'{4'd7, 4'd0, 4'd4, 4'd6, 4'd9, 4'd1, 4'd3, 4'd2, 4'd5, 4'd8}
	};

endpackage

// File: sv/idv_char_decode.sv
module idv_char_decode
	import idv_pkg::*;
(
	input  item_t       item,
	output char_class_t cls
);

	logic is_digit;
	logic is_skip;
	logic [7:0] offset;

	// Sort the character into digit, whitespace or hyphen, or bad.
	always_comb begin
		offset   = item.char_code - CHAR_ZERO;
		is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
		is_skip  = (item.char_code == CHAR_SPACE) || (item.char_code == CHAR_HYPHEN) ||
			((item.char_code >= CHAR_TAB) && (item.char_code <= CHAR_CR));
		cls.is_digit = item.has_char && is_digit;
		cls.is_bad   = item.has_char && !is_digit && !is_skip;
		cls.digit    = offset[3:0];
	end

endmodule

// File: sv/idv_accum.sv
module idv_accum
	import idv_pkg::*;
#(
	parameter int unsigned COUNT_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  item_t       item,
	input  char_class_t cls,
	output result_t     result
);

	localparam int unsigned CW = $clog2(COUNT_MAX + 1);

	logic [3:0]    accum_q;
	logic [CW-1:0] count_q;
	logic          bad_q;
	logic [7:0]    code_q;
	logic          lead_q;

	logic [3:0]    accum_upd;
	logic [CW-1:0] count_upd;
	logic          bad_upd;
	logic [7:0]    code_upd;
	logic          lead_upd;
	logic [2:0]    row;
	logic [3:0]    perm_val;

	// Fold the current character into the running state.
	always_comb begin
		row       = 3'(4'(ID_DIGITS - 1) - count_q[3:0]);
		perm_val  = GRP_PERM[row][cls.digit];
		accum_upd = accum_q;
		count_upd = count_q;
		bad_upd   = bad_q;
		code_upd  = code_q;
		lead_upd  = lead_q;
		if (cls.is_digit) begin
			if ((count_q == '0) && (cls.digit < 4'd2)) begin
				lead_upd = 1'b1;
			end
			if (count_q < CW'(ID_DIGITS)) begin
				accum_upd = GRP_MUL[perm_val][accum_q];
			end
			if (count_q < CW'(COUNT_MAX)) begin
				count_upd = count_q + 1'b1;
			end
		end else if (cls.is_bad && !bad_q) begin
			bad_upd  = 1'b1;
			code_upd = item.char_code;
		end
	end

	// Verdict for the string, in order of precedence.
	always_comb begin
		if (bad_upd) begin
			result.status = STATUS_BAD_CHAR;
		end else if (count_upd != CW'(ID_DIGITS)) begin
			result.status = STATUS_BAD_LEN;
		end else if (lead_upd) begin
			result.status = STATUS_BAD_LEAD;
		end else if (accum_upd != 4'd0) begin
			result.status = STATUS_BAD_CHECK;
		end else begin
			result.status = STATUS_OK;
		end
		result.bad_char    = bad_upd ? code_upd : 8'd0;
		result.digit_count = 8'(count_upd);
	end

	// State registers; the last item of a string clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
			code_q  <= '0;
			lead_q  <= 1'b0;
		end else if (take) begin
			if (item.is_last) begin
				accum_q <= '0;
				count_q <= '0;
				bad_q   <= 1'b0;
				code_q  <= '0;
				lead_q  <= 1'b0;
			end else begin
				accum_q <= accum_upd;
				count_q <= count_upd;
				bad_q   <= bad_upd;
				code_q  <= code_upd;
				lead_q  <= lead_upd;
			end
		end
	end

endmodule

// File: sv/id_number_verhoeff_validator.sv
// ID number validator with a Verhoeff check digit.
//
// The item channel carries a string one character per transaction; the item
// flagged is_last closes the string. An item with has_char low carries no
// character but may still close the string. The result channel carries one
// verdict per string: status, the first bad character and the digit count.
//
// Timing: an item taken into the input register is folded into the running state
// when it moves on; for a last item the result register is loaded at the same
// time, and the result is shown from then on. Throughput: one item per cycle
// unless a last item waits on a stalled result, set by the single accumulator
// update (two table lookups) between input register and state registers.
//
// Reset clears all string state and both pipeline stages; the block takes a
// new string right away. When the receiver stalls a shown result, the block
// keeps taking characters of the next string; only a second last item waits
// in the input register, and item_stall is raised until the result is gone.
module id_number_verhoeff_validator
	import idv_pkg::*;
#(
	parameter int unsigned COUNT_MAX = 255
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	logic        take;
	char_class_t cls;
	result_t     verdict;

	// A last item moves on only when the result register has room.
	assign advance    = !item_s1.is_last || !result_valid || !result_stall;
	assign take       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	idv_char_decode u_decode (
		.item (item_s1),
		.cls  (cls)
	);

	idv_accum #(
		.COUNT_MAX (COUNT_MAX)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.cls    (cls),
		.result (verdict)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || !result_stall) begin
			result_valid <= take && item_s1.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.is_last) begin
			result <= verdict;
		end
	end

	// A new result appears only after a last item was folded in.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(take && item_s1.is_last))
		else $error("result shown without a closing item");

	// The input side waits only behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && item_s1.is_last && result_valid && result_stall))
		else $error("item stalled without a blocked result");

	// A passing verdict always covers exactly twelve digits and no bad character.
	a_ok_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == STATUS_OK)) |->
		((result.digit_count == 8'd12) && (result.bad_char == 8'd0)))
		else $error("passing verdict with wrong digit count or bad character");

endmodule
